// ===== hdl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

	// Result field widths
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned ROOM_W  = 8;

	// Smallest room that lets a conversion go ahead
	localparam logic [ROOM_W-1:0] MIN_ROOM = 8'd21;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [3:0]        CHAR_DIGIT_HI = 4'h3; // '0'..'9' are 0x30..0x39

	// Job flags carried from the front end to the back end
	typedef struct packed {
		logic neg;
		logic err;
	} sbda_job_t;

	localparam int unsigned JOB_W = $bits(sbda_job_t);

endpackage

// ===== hdl/sbda_front.sv =====
// ----------------------------------------------------------------------------
// sbda_front
// Accepts input beats, takes the magnitude and sign of the value, checks the
// room, and holds the jobs in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sbda_front #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [63:0]                     value,
	input  logic [sbda_pkg::ROOM_W-1:0]     room,
	output logic                            job_valid,
	input  logic                            job_pop,
	output sbda_pkg::sbda_job_t             job_flags,
	output logic [VALUE_BITS-1:0]           job_mag
);
	import sbda_pkg::*;

	localparam int unsigned ENTRY_W = JOB_W + VALUE_BITS;

	logic [VALUE_BITS-1:0] v;
	logic [VALUE_BITS-1:0] mag;
	sbda_job_t             flags;
	logic                  push;
	logic                  pop;
	logic [ENTRY_W-1:0]    entry_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fill_q;

	// Classify the incoming beat
	always_comb begin
		v         = value[VALUE_BITS-1:0];
		flags.neg = v[VALUE_BITS-1];
		flags.err = (room < MIN_ROOM);
		mag       = flags.neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;
	end

	assign in_ready  = (fill_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign job_valid = (fill_q != 2'd0);
	assign pop       = job_pop && job_valid;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= {flags, mag};
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	assign job_flags = entry_q[rd_ptr_q][ENTRY_W-1 -: JOB_W];
	assign job_mag   = entry_q[rd_ptr_q][VALUE_BITS-1:0];

endmodule

// ===== hdl/sbda_back.sv =====
// ----------------------------------------------------------------------------
// sbda_back
// Bit-serial double dabble conversion of one magnitude into BCD, then one
// ASCII character per output beat: sign if negative, digits, terminator (a refused job gives the terminator alone).
// ----------------------------------------------------------------------------
module sbda_back #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	output logic                            job_pop,
	input  sbda_pkg::sbda_job_t             job_flags,
	input  logic [VALUE_BITS-1:0]           job_mag,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sbda_pkg::CHAR_W-1:0]     character,
	output logic                            last,
	output logic [sbda_pkg::COUNT_W-1:0]    byte_count,
	output logic                            error
);
	import sbda_pkg::*;

	// Decimal digits needed for an unsigned magnitude of VALUE_BITS bits
	localparam int unsigned DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int unsigned BCD_W  = 4 * DIGITS;
	localparam int unsigned BIT_W  = $clog2(VALUE_BITS);
	localparam int unsigned LEFT_W = $clog2(DIGITS + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CONV  = 6'b000010,
		ST_SIGN  = 6'b000100,
		ST_SKIP  = 6'b001000,
		ST_DIGIT = 6'b010000,
		ST_TERM  = 6'b100000
	} sbda_state_t;

	sbda_state_t           state_q;
	sbda_job_t             job_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [BIT_W-1:0]      bit_q;
	logic [LEFT_W-1:0]     left_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic [3:0]            top_digit;
	logic                  can_load;
	logic                  load;

	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  error_q;

	// Add-3 correction on every BCD digit before the shift
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ?
				(bcd_q[4*d +: 4] + 4'd3) : bcd_q[4*d +: 4];
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign can_load  = !out_valid_q || out_ready;
	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	// Output register takes a new beat in the emitting states
	assign load      = can_load && ((state_q == ST_SIGN) || (state_q == ST_DIGIT) ||
		(state_q == ST_TERM));

	// Sequencer and conversion datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			bit_q       <= '0;
			left_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q  <= job_flags;
						mag_q  <= job_mag;
						bcd_q  <= '0;
						bit_q  <= '0;
						left_q <= LEFT_W'(DIGITS);
						cnt_q  <= '0;
						state_q <= job_flags.err ? ST_TERM : ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
					mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
					bit_q <= bit_q + BIT_W'(1);
					if (bit_q == BIT_W'(VALUE_BITS - 1)) begin
						state_q <= job_q.neg ? ST_SIGN : ST_SKIP;
					end
				end
				ST_SIGN: begin
					if (can_load) begin
						char_q      <= CHAR_MINUS;
						last_q      <= 1'b0;
						count_q     <= '0;
						error_q     <= 1'b0;
						cnt_q       <= cnt_q + COUNT_W'(1);
						state_q     <= ST_SKIP;
					end
				end
				// Drop leading zeros, keeping at least one digit
				ST_SKIP: begin
					if ((top_digit == 4'd0) && (left_q > LEFT_W'(1))) begin
						bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
						left_q <= left_q - LEFT_W'(1);
					end else begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (can_load) begin
						char_q      <= {CHAR_DIGIT_HI, top_digit};
						last_q      <= 1'b0;
						count_q     <= '0;
						error_q     <= 1'b0;
						cnt_q       <= cnt_q + COUNT_W'(1);
						bcd_q       <= {bcd_q[BCD_W-5:0], 4'd0};
						left_q      <= left_q - LEFT_W'(1);
						if (left_q == LEFT_W'(1)) begin
							state_q <= ST_TERM;
						end
					end
				end
				ST_TERM: begin
					if (can_load) begin
						char_q      <= CHAR_NUL;
						last_q      <= 1'b1;
						count_q     <= cnt_q + COUNT_W'(1);
						error_q     <= job_q.err;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign last       = last_q;
	assign byte_count = count_q;
	assign error      = error_q;

endmodule

// ===== hdl/signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed number to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// Sequence: the input beat is queued, then its magnitude is converted bit by bit
//   by double dabble; a sign is emitted if negative, leading zeros are skipped,
//   then digits and terminator follow one per cycle when the output does not stall.
//   A refused item gives the terminator alone. One item converts at a time;
//   a two-entry queue decouples, so new inputs are taken while one converts.
// Reset: arst_n clears the queue, the sequencer and the output valid at once.
module signed_binary_to_decimal_ascii #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [63:0]                     value,
	input  logic [sbda_pkg::ROOM_W-1:0]     room,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sbda_pkg::CHAR_W-1:0]     character,
	output logic                            last,
	output logic [sbda_pkg::COUNT_W-1:0]    byte_count,
	output logic                            error
);
	import sbda_pkg::*;

	logic                  job_valid;
	logic                  job_pop;
	sbda_job_t             job_flags;
	logic [VALUE_BITS-1:0] job_mag;

	// Front end: classify and queue
	sbda_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.room      (room),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job_flags (job_flags),
		.job_mag   (job_mag)
	);

	// Back end: convert and emit
	sbda_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_pop    (job_pop),
		.job_flags  (job_flags),
		.job_mag    (job_mag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.last       (last),
		.byte_count (byte_count),
		.error      (error)
	);

endmodule
